// ===== rtl/core/ifb_pkg.sv =====
package ifb_pkg;

	// Default store geometry
	localparam int IFB_MAX_WIDTH  = 256;
	localparam int IFB_MAX_HEIGHT = 256;

	// Configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PASS_COUNT   = 2'd2;

	localparam logic [8:0] RST_IMAGE_WIDTH  = 9'd256;
	localparam logic [8:0] RST_IMAGE_HEIGHT = 9'd256;
	localparam logic [3:0] RST_PASS_COUNT   = 4'd4;

	// Item operation codes
	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_READ  = 2'd1;
	localparam logic [1:0] FN_BLUR  = 2'd2;
	localparam logic [1:0] FN_NOP   = 2'd3;

	// Read address select
	localparam logic [2:0] RD_PIX   = 3'd0;
	localparam logic [2:0] RD_LEFT  = 3'd1;
	localparam logic [2:0] RD_RIGHT = 3'd2;
	localparam logic [2:0] RD_UP    = 3'd3;
	localparam logic [2:0] RD_DOWN  = 3'd4;

	// Result source select
	localparam logic [1:0] RES_IMM  = 2'd0;
	localparam logic [1:0] RES_READ = 2'd1;
	localparam logic [1:0] RES_BLUR = 2'd2;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] pixel_addr;
		logic [7:0]  pixel_in;
	} ifb_req_t;

	typedef struct packed {
		logic [7:0] pixel_out;
		logic       addr_error;
		logic       op_done;
	} ifb_rsp_t;

	typedef struct packed {
		logic       wr_pix;     // store the item's pixel
		logic [2:0] rd_sel;
		logic       res_load;
		logic [1:0] res_sel;
		logic       blur_init;
		logic       pass_init;
		logic       pass_inc;
		logic       cap_left;
		logic       cap_right;
		logic       cap_up;
		logic       px_write;   // write back blurred pixel
		logic       step_col;
		logic       step_row;
	} ifb_cmd_t;

	typedef struct packed {
		logic addr_err;
		logic blur_skip;
		logic last_col;
		logic last_row;
		logic last_pass;
	} ifb_stat_t;

endpackage

// ===== rtl/core/ifb_stream_if.sv =====
interface ifb_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/core/inplace_four_neighbour_blur.sv =====
// Grey frame store with an in-place four-neighbor blur. Each req item writes a
// pixel, reads a pixel or runs the blur, and yields exactly one rsp item.
// Writes, out-of-range accesses, blurs that have nothing to do and unused codes
// produce their result in the cycle after acceptance; a read passes through the
// registered read port of the store and then the result register. A blur holds
// the block busy for pass_count passes over the image geometry clamped to
// MAX_WIDTH/MAX_HEIGHT: the single read port of the frame store is visited
// three times per interior pixel (right, up, down neighbors) plus a write-back
// step, with one extra read at each row start. A new item is taken once the
// block is idle and the previous result has left or is leaving.
// The store is not cleared at reset; pixels must be written before use.
module inplace_four_neighbour_blur import ifb_pkg::*; #(
	parameter int MAX_WIDTH  = IFB_MAX_WIDTH,
	parameter int MAX_HEIGHT = IFB_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	ifb_stream_if.sink            req,
	ifb_stream_if.source          rsp
);

	ifb_cmd_t  cmd;
	ifb_stat_t stat;

	ifb_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_func  (req.data.func),
		.rsp_ready (rsp.ready),
		.stat      (stat),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.cmd       (cmd)
	);

	ifb_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req_data (req.data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp_data (rsp.data)
	);

endmodule

// ===== rtl/core/ifb_ram.sv =====
module ifb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/core/ifb_datapath.sv =====
module ifb_datapath import ifb_pkg::*; #(
	parameter int MAX_WIDTH  = IFB_MAX_WIDTH,
	parameter int MAX_HEIGHT = IFB_MAX_HEIGHT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  ifb_req_t              req_data,
	input  ifb_cmd_t              cmd,
	output ifb_stat_t             stat,
	output ifb_rsp_t              rsp_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	logic [8:0]  image_width_q;
	logic [8:0]  image_height_q;
	logic [3:0]  pass_count_q;

	logic [8:0]  eff_w;
	logic [8:0]  eff_h;
	logic [17:0] limit;
	logic        is_rw;

	logic [AW-1:0] at_q;
	logic [8:0]    col_q;
	logic [8:0]    row_q;
	logic [3:0]    pass_q;
	logic [7:0]    left_q;
	logic [7:0]    right_q;
	logic [7:0]    up_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [7:0]    ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [7:0]    ram_rdata;
	logic [9:0]    sum;
	logic [7:0]    new_px;

	ifb_rsp_t res_q;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q  <= RST_IMAGE_WIDTH;
			image_height_q <= RST_IMAGE_HEIGHT;
			pass_count_q   <= RST_PASS_COUNT;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_IMAGE_WIDTH:  image_width_q  <= cfg_data[8:0];
				REG_IMAGE_HEIGHT: image_height_q <= cfg_data[8:0];
				REG_PASS_COUNT:   pass_count_q   <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// Geometry clamped to the store
	assign eff_w = (32'(image_width_q) > MAX_WIDTH) ? 9'(MAX_WIDTH) : image_width_q;
	assign eff_h = (32'(image_height_q) > MAX_HEIGHT) ? 9'(MAX_HEIGHT) : image_height_q;
	assign limit = 18'(eff_w) * 18'(eff_h);
	assign is_rw = req_data.func inside {FN_WRITE, FN_READ};

	assign stat.addr_err  = 18'(req_data.pixel_addr) >= limit;
	assign stat.blur_skip = (eff_w <= 9'd2) || (eff_h <= 9'd2) || (pass_count_q == 4'd0);
	assign stat.last_col  = (10'(col_q) + 10'd2) == 10'(eff_w);
	assign stat.last_row  = (10'(row_q) + 10'd2) == 10'(eff_h);
	assign stat.last_pass = (5'(pass_q) + 5'd1) == 5'(pass_count_q);

	// Blur walk: at_q is the address of the current interior pixel
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			at_q   <= '0;
			col_q  <= '0;
			row_q  <= '0;
			pass_q <= '0;
		end else begin
			if (cmd.blur_init) begin
				pass_q <= '0;
			end else if (cmd.pass_inc) begin
				pass_q <= pass_q + 4'd1;
			end
			if (cmd.pass_init) begin
				at_q  <= AW'(eff_w) + AW'(1);
				col_q <= 9'd1;
				row_q <= 9'd1;
			end else if (cmd.step_col) begin
				at_q  <= at_q + AW'(1);
				col_q <= col_q + 9'd1;
			end else if (cmd.step_row) begin
				// skip right border and left border of next row
				at_q  <= at_q + AW'(3);
				col_q <= 9'd1;
				row_q <= row_q + 9'd1;
			end
		end
	end

	always_comb begin
		case (cmd.rd_sel)
			RD_LEFT:  ram_raddr = at_q - AW'(1);
			RD_RIGHT: ram_raddr = at_q + AW'(1);
			RD_UP:    ram_raddr = at_q - AW'(eff_w);
			RD_DOWN:  ram_raddr = at_q + AW'(eff_w);
			default:  ram_raddr = AW'(req_data.pixel_addr);
		endcase
	end

	// Left neighbor already holds this pass's value; down comes straight off the RAM
	assign sum    = 10'(left_q) + 10'(right_q) + 10'(up_q) + 10'(ram_rdata);
	assign new_px = sum[9:2];

	always_ff @(posedge clk) begin
		if (cmd.cap_left) begin
			left_q <= ram_rdata;
		end else if (cmd.px_write) begin
			left_q <= new_px;
		end
		if (cmd.cap_right) begin
			right_q <= ram_rdata;
		end
		if (cmd.cap_up) begin
			up_q <= ram_rdata;
		end
	end

	assign ram_we    = cmd.wr_pix || cmd.px_write;
	assign ram_waddr = cmd.px_write ? at_q : AW'(req_data.pixel_addr);
	assign ram_wdata = cmd.px_write ? new_px : req_data.pixel_in;

	ifb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			case (cmd.res_sel)
				RES_READ: begin
					res_q.pixel_out  <= ram_rdata;
					res_q.addr_error <= 1'b0;
					res_q.op_done    <= 1'b1;
				end
				RES_BLUR: begin
					res_q.pixel_out  <= 8'd0;
					res_q.addr_error <= 1'b0;
					res_q.op_done    <= 1'b1;
				end
				default: begin
					res_q.pixel_out  <= 8'd0;
					res_q.addr_error <= is_rw && stat.addr_err;
					res_q.op_done    <= (is_rw && !stat.addr_err) ||
						(req_data.func == FN_BLUR);
				end
			endcase
		end
	end

	assign rsp_data = res_q;

endmodule

// ===== rtl/core/ifb_ctrl.sv =====
module ifb_ctrl import ifb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       req_valid,
	input  logic [1:0] req_func,
	input  logic       rsp_ready,
	input  ifb_stat_t  stat,
	output logic       req_ready,
	output logic       rsp_valid,
	output ifb_cmd_t   cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_RDW  = 4'd1;
	localparam logic [3:0] S_PASS = 4'd2;
	localparam logic [3:0] S_ROW  = 4'd3;
	localparam logic [3:0] S_PRF  = 4'd4;
	localparam logic [3:0] S_PR   = 4'd5;
	localparam logic [3:0] S_PU   = 4'd6;
	localparam logic [3:0] S_PD   = 4'd7;
	localparam logic [3:0] S_PW   = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       out_valid_q;
	logic       accept;

	assign req_ready = (state_q == S_IDLE) && (!out_valid_q || rsp_ready);
	assign accept    = req_valid && req_ready;
	assign rsp_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				cmd.rd_sel = RD_PIX;
				if (accept) begin
					case (req_func)
						FN_WRITE: begin
							cmd.wr_pix   = !stat.addr_err;
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_IMM;
						end
						FN_READ: begin
							if (stat.addr_err) begin
								cmd.res_load = 1'b1;
								cmd.res_sel  = RES_IMM;
							end else begin
								state_d = S_RDW;
							end
						end
						FN_BLUR: begin
							if (stat.blur_skip) begin
								cmd.res_load = 1'b1;
								cmd.res_sel  = RES_IMM;
							end else begin
								cmd.blur_init = 1'b1;
								state_d       = S_PASS;
							end
						end
						default: begin
							cmd.res_load = 1'b1;
							cmd.res_sel  = RES_IMM;
						end
					endcase
				end
			end
			S_RDW: begin
				cmd.res_load = 1'b1;
				cmd.res_sel  = RES_READ;
				state_d      = S_IDLE;
			end
			S_PASS: begin
				cmd.pass_init = 1'b1;
				state_d       = S_ROW;
			end
			S_ROW: begin
				cmd.rd_sel = RD_LEFT;
				state_d    = S_PRF;
			end
			S_PRF: begin
				cmd.rd_sel   = RD_RIGHT;
				cmd.cap_left = 1'b1;
				state_d      = S_PU;
			end
			S_PR: begin
				cmd.rd_sel = RD_RIGHT;
				state_d    = S_PU;
			end
			S_PU: begin
				cmd.rd_sel    = RD_UP;
				cmd.cap_right = 1'b1;
				state_d       = S_PD;
			end
			S_PD: begin
				cmd.rd_sel = RD_DOWN;
				cmd.cap_up = 1'b1;
				state_d    = S_PW;
			end
			S_PW: begin
				cmd.px_write = 1'b1;
				if (!stat.last_col) begin
					cmd.step_col = 1'b1;
					state_d      = S_PR;
				end else if (!stat.last_row) begin
					cmd.step_row = 1'b1;
					state_d      = S_ROW;
				end else if (!stat.last_pass) begin
					cmd.pass_inc = 1'b1;
					state_d      = S_PASS;
				end else begin
					cmd.res_load = 1'b1;
					cmd.res_sel  = RES_BLUR;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/ifb_checker.sv =====
module ifb_checker import ifb_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     req_valid,
	input logic     req_ready,
	input ifb_req_t req_data,
	input logic     rsp_valid,
	input logic     rsp_ready,
	input ifb_rsp_t rsp_data
);

	// A stalled result blocks new items
	a_no_accept_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |-> !req_ready)
		else $error("item taken while result stalled");

	a_err_done_excl: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !(rsp_data.addr_error && rsp_data.op_done))
		else $error("addr_error and op_done both set");

	// Undefined code yields an all-zero result on the next cycle
	a_nop_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_data.func == FN_NOP) |=>
		(rsp_valid && !rsp_data.op_done && !rsp_data.addr_error &&
		rsp_data.pixel_out == 8'd0))
		else $error("bad result for undefined code");

	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && req_ready && req_data.func == FN_WRITE) |=>
		(rsp_valid && rsp_data.pixel_out == 8'd0))
		else $error("bad result for pixel write");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
		else $error("stalled result changed");

endmodule

bind inplace_four_neighbour_blur ifb_checker u_ifb_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_data  (req.data),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import ifb_pkg::*;

	localparam int ITEM_TARGET = 1450;
	localparam int CYCLE_LIMIT = 6_000_000;
	localparam int STORE_DEPTH = IFB_MAX_WIDTH * IFB_MAX_HEIGHT;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	ifb_stream_if #(.T(ifb_req_t)) req_if ();
	ifb_stream_if #(.T(ifb_rsp_t)) rsp_if ();

	inplace_four_neighbour_blur u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.req      (req_if),
		.rsp      (rsp_if)
	);

	always #6 clk = ~clk;

	// shadow frame store and geometry
	bit [7:0] frame_pix [0:STORE_DEPTH-1];
	bit       frame_set [0:STORE_DEPTH-1];
	int       wr_list[$];
	bit [8:0] geo_w;
	bit [8:0] geo_h;
	bit [3:0] geo_passes;

	ifb_rsp_t rsp_owed[$];
	int       err_count;
	int       sent_count;
	int       cycle_count;
	bit       calm_tail;

	function automatic int img_w();
		return (geo_w > IFB_MAX_WIDTH) ? IFB_MAX_WIDTH : int'(geo_w);
	endfunction

	function automatic int img_h();
		return (geo_h > IFB_MAX_HEIGHT) ? IFB_MAX_HEIGHT : int'(geo_h);
	endfunction

	function automatic void blur_frame(int w, int h);
		int at;
		int sum;
		if (w <= 2 || h <= 2) return;
		for (int p = 0; p < int'(geo_passes); p++) begin
			for (int r = 1; r < h - 1; r++) begin
				for (int c = 1; c < w - 1; c++) begin
					// left and upper neighbors already hold this pass's values
					at = r * w + c;
					sum = frame_pix[at - 1] + frame_pix[at + 1] + frame_pix[at - w]
						+ frame_pix[at + w];
					frame_pix[at] = 8'(sum >> 2);
				end
			end
		end
	endfunction

	function automatic ifb_rsp_t apply_pixel_cmd(ifb_req_t cmd);
		ifb_rsp_t res;
		int       lim;
		int       a;
		res = '0;
		lim = img_w() * img_h();
		a = int'(cmd.pixel_addr);
		case (cmd.func)
			FN_WRITE, FN_READ: begin
				if (a >= lim) begin
					res.addr_error = 1'b1;
				end else begin
					if (cmd.func == FN_WRITE) begin
						frame_pix[a] = cmd.pixel_in;
						if (!frame_set[a]) begin
							frame_set[a] = 1'b1;
							wr_list = {wr_list, a};
						end
					end else begin
						res.pixel_out = frame_pix[a];
					end
					res.op_done = 1'b1;
				end
			end
			FN_BLUR: begin
				blur_frame(img_w(), img_h());
				res.op_done = 1'b1;
			end
			default: ;
		endcase
		return res;
	endfunction

	// a blur may only touch pixels that hold written values
	function automatic bit blur_ok();
		int lim;
		if (img_w() <= 2 || img_h() <= 2 || geo_passes == 0) return 1'b1;
		lim = img_w() * img_h();
		for (int i = 0; i < lim; i++) begin
			if (!frame_set[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic logic [7:0] rand_pixel();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic log_mismatch(input string msg);
		err_count++;
		if (err_count <= 200) $display("%0t mismatch: %s", $time, msg);
	endtask

	// result checker
	always @(posedge clk) begin
		ifb_rsp_t got;
		ifb_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got = rsp_if.data;
			if (rsp_owed.size() == 0) begin
				log_mismatch($sformatf("unexpected item %h", got));
			end else begin
				want = rsp_owed.pop_front();
				if (got.pixel_out !== want.pixel_out)
					log_mismatch($sformatf("pixel_out %h, want %h", got.pixel_out,
						want.pixel_out));
				if (got.addr_error !== want.addr_error)
					log_mismatch($sformatf("addr_error %b, want %b", got.addr_error,
						want.addr_error));
				if (got.op_done !== want.op_done)
					log_mismatch($sformatf("op_done %b, want %b", got.op_done,
						want.op_done));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("status: fail");
			$finish;
		end
	end

	// receiver back-pressure
	initial begin
		int stall;
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (!calm_tail && $urandom_range(0, 7) == 0) begin
				stall = $urandom_range(1, 11);
				rsp_if.ready = 1'b0;
				repeat (stall - 1) @(negedge clk);
			end else begin
				rsp_if.ready = 1'b1;
			end
		end
	end

	// Called at a falling edge; returns at a falling edge with valid still high,
	// so the caller either sends again or drops valid in the same step.
	task automatic send_cmd(input logic [1:0] fn, input logic [15:0] addr,
		input logic [7:0] pix);
		ifb_req_t cmd;
		ifb_rsp_t exp_rsp;
		int       gap;
		cmd.func = fn;
		cmd.pixel_addr = addr;
		cmd.pixel_in = pix;
		gap = (!calm_tail && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
		if (gap > 0) begin
			req_if.valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_if.data = cmd;
		req_if.valid = 1'b1;
		@(posedge clk);
		while (!req_if.ready) @(posedge clk);
		exp_rsp = apply_pixel_cmd(cmd);
		rsp_owed = {rsp_owed, exp_rsp};
		sent_count++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		req_if.valid = 1'b0;
		while (rsp_owed.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic set_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_we = 1'b1;
		cfg_idx = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_IMAGE_WIDTH: geo_w = val;
			REG_IMAGE_HEIGHT: geo_h = val;
			REG_PASS_COUNT: geo_passes = val[3:0];
			default: ;
		endcase
	endtask

	task automatic set_geometry(input int w, input int h, input int p);
		wait_drained();
		set_reg(REG_IMAGE_WIDTH, 9'(w));
		set_reg(REG_IMAGE_HEIGHT, 9'(h));
		set_reg(REG_PASS_COUNT, 9'(p));
	endtask

	task automatic fill_image();
		int lim;
		lim = img_w() * img_h();
		for (int a = 0; a < lim; a++) send_cmd(FN_WRITE, 16'(a), rand_pixel());
	endtask

	task automatic test_reset_defaults();
		send_cmd(FN_WRITE, 16'h0000, 8'hFF);
		send_cmd(FN_WRITE, 16'hFFFF, 8'h00);
		send_cmd(FN_READ, 16'h0000, 8'h00);
		send_cmd(FN_READ, 16'hFFFF, 8'hFF);
		send_cmd(FN_NOP, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_oversized_geometry();
		// clamps to the full store
		set_geometry(511, 300, 4);
		send_cmd(FN_WRITE, 16'hFFFE, 8'h5A);
		send_cmd(FN_READ, 16'hFFFE, 8'hA5);
		// last row cut off
		set_geometry(256, 255, 4);
		send_cmd(FN_READ, 16'hFFFF, 8'h00);
		send_cmd(FN_WRITE, 16'hFF00, 8'h01);
	endtask

	task automatic test_zero_geometry();
		set_geometry(0, 5, 4);
		send_cmd(FN_WRITE, 16'h0000, 8'h33);
		send_cmd(FN_BLUR, 16'h0000, 8'h00);
		set_geometry(4, 0, 4);
		send_cmd(FN_READ, 16'h0000, 8'h00);
	endtask

	task automatic test_thin_image();
		set_geometry(2, 200, 15);
		send_cmd(FN_BLUR, 16'h1234, 8'h00);
		send_cmd(FN_READ, 16'h0000, 8'h00);
	endtask

	task automatic test_zero_passes();
		set_geometry(256, 256, 0);
		send_cmd(FN_BLUR, 16'hFFFF, 8'hFF);
	endtask

	task automatic test_min_blur();
		set_geometry(3, 3, 1);
		fill_image();
		send_cmd(FN_BLUR, 16'h0000, 8'h00);
		send_cmd(FN_READ, 16'h0004, 8'h00);
	endtask

	task automatic run_random_phase();
		int w;
		int h;
		int p;
		int lim;
		int k;
		case ($urandom_range(0, 3))
			0: p = 0;
			1: p = 15;
			default: p = $urandom_range(1, 15);
		endcase
		case ($urandom_range(0, 9))
			0: begin
				w = $urandom_range(0, 2);
				h = $urandom_range(0, 300);
			end
			1: begin
				w = $urandom_range(3, 40);
				h = $urandom_range(0, 2);
			end
			2: begin
				w = $urandom_range(200, 511);
				h = $urandom_range(200, 511);
			end
			3: begin
				w = $urandom_range(13, 64);
				h = $urandom_range(3, 4);
			end
			4: begin
				w = 3;
				h = 3;
			end
			default: begin
				w = $urandom_range(3, 12);
				h = $urandom_range(3, 12);
			end
		endcase
		set_geometry(w, h, p);
		lim = img_w() * img_h();
		if (lim > 0 && lim <= 300 && $urandom_range(0, 4) != 0) fill_image();
		repeat ($urandom_range(20, 50)) begin
			if (sent_count > ITEM_TARGET - 150) calm_tail = 1'b1;
			k = $urandom_range(0, 99);
			if (k < 36 && lim > 0) begin
				send_cmd(FN_WRITE, 16'($urandom_range(0, lim - 1)), rand_pixel());
			end else if (k < 66 && wr_list.size() > 0) begin
				send_cmd(FN_READ, 16'(wr_list[$urandom_range(0, wr_list.size() - 1)]),
					8'($urandom));
			end else if (k < 80) begin
				if (lim < STORE_DEPTH)
					send_cmd(($urandom_range(0, 1) != 0) ? FN_READ : FN_WRITE,
						16'($urandom_range(lim, STORE_DEPTH - 1)), rand_pixel());
				else
					send_cmd(FN_WRITE, 16'($urandom), rand_pixel());
			end else if (k < 87 && blur_ok()) begin
				send_cmd(FN_BLUR, 16'($urandom), 8'($urandom));
			end else if (k < 93) begin
				send_cmd(FN_NOP, 16'($urandom), 8'($urandom));
			end else if (k < 96 && !calm_tail) begin
				// sender holds off until every result is back
				wait_drained();
			end else begin
				send_cmd(FN_WRITE, 16'($urandom), rand_pixel());
			end
		end
	endtask

	task automatic test_random_traffic();
		while (sent_count < ITEM_TARGET) run_random_phase();
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_idx = '0;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.data = '0;
		geo_w = RST_IMAGE_WIDTH;
		geo_h = RST_IMAGE_HEIGHT;
		geo_passes = RST_PASS_COUNT;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_defaults();
		test_oversized_geometry();
		test_zero_geometry();
		test_thin_image();
		test_zero_passes();
		test_min_blur();
		test_random_traffic();

		wait_drained();
		repeat (20) @(posedge clk);
		if (err_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule
